FILE: rtl/aes_pkg.sv
// AES-128 encryption core: shared types, S-box and GF(2^8) helpers.
// No dependencies; imported by the controller, datapath and top level.
package aes_pkg;

    localparam logic [7:0] GF_POLY = 8'h1b;
    localparam logic [3:0] NUM_ROUNDS = 4'd10;

    // Controller to datapath
    typedef struct packed {
        logic load;    // take plaintext, do initial key add
        logic round;   // run one round
        logic last;    // final round, no MixColumns
    } t_dp_cmd;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        unique case (a)
            8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
            8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
            8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
            8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
            8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
            8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
            8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
            8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
            8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
            8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
            8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
            8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
            8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
            8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
            8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
            8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
            8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
            8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
            8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
            8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
            8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
            8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
            8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
            8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
            8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
            8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
            8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
            8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
            8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
            8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
            8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
            8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
            8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
            8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
            8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
            8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
            8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
            8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
            8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
            8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
            8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
            8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
            8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
            8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
            8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
            8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
            8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
            8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
            8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
            8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
            8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
            8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
            8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
            8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
            8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
            8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
            8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
            8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
            8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
            8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
            8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
            8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
            8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
            8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY : 8'h00);
    endfunction

endpackage

FILE: rtl/aes_ctrl.sv
// AES-128 controller: handshake and round sequencing.
// Depends on aes_pkg (t_dp_cmd, NUM_ROUNDS).
module aes_ctrl import aes_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_ready,
    output t_dp_cmd o_cmd
);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] r_state, n_state;
    logic [3:0] r_rnd, n_rnd;

    assign o_ready = (r_state == ST_IDLE);
    assign o_valid = (r_state == ST_DONE);

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_rnd      = 4'd1;
                    n_state    = ST_RUN;
                end
            end
            ST_RUN: begin
                o_cmd.round = 1'b1;
                o_cmd.last  = (r_rnd == NUM_ROUNDS);
                n_rnd       = r_rnd + 4'd1;
                if (r_rnd == NUM_ROUNDS) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            r_rnd   <= n_rnd;
        end
    end
endmodule

FILE: rtl/aes_dpath.sv
// AES-128 datapath: state and round-key registers, one round per cycle,
// key expanded on the fly. Depends on aes_pkg (sbox, xtime, t_dp_cmd).
module aes_dpath import aes_pkg::*; (
    input  logic          i_clk,
    input  t_dp_cmd       i_cmd,
    input  logic [127:0]  i_key,
    input  logic [127:0]  i_plain,
    output logic [127:0]  o_block
);
    logic [127:0] r_blk, r_key;
    logic [7:0]   r_rc;
    logic [127:0] sb, mc, nk;
    logic [31:0]  tw;

    // SubBytes + ShiftRows: out (r,c) from in (r,(c+r)%4)
    always_comb begin
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                sb[8*(r+4*c) +: 8] = sbox(r_blk[8*(r+4*((c+r)%4)) +: 8]);
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3;
            a0 = sb[32*c +: 8]; a1 = sb[32*c+8 +: 8];
            a2 = sb[32*c+16 +: 8]; a3 = sb[32*c+24 +: 8];
            mc[32*c    +: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            mc[32*c+8  +: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            mc[32*c+16 +: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            mc[32*c+24 +: 8] = a0 ^ xtime(a0) ^ a1 ^ a2 ^ xtime(a3);
        end
    end

    // Next round key: RotWord/SubWord of column 3, then running xor
    always_comb begin
        tw = {sbox(r_key[103:96]), sbox(r_key[127:120]),
              sbox(r_key[119:112]), sbox(r_key[111:104]) ^ r_rc};
        nk[31:0]   = r_key[31:0] ^ tw;
        nk[63:32]  = r_key[63:32] ^ nk[31:0];
        nk[95:64]  = r_key[95:64] ^ nk[63:32];
        nk[127:96] = r_key[127:96] ^ nk[95:64];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_blk <= i_plain ^ i_key;
            r_key <= i_key;
            r_rc  <= 8'h01;
        end else if (i_cmd.round) begin
            r_blk <= (i_cmd.last ? sb : mc) ^ nk;
            r_key <= nk;
            r_rc  <= xtime(r_rc);
        end
    end

    assign o_block = r_blk;
endmodule

FILE: rtl/aes128_block_encrypt_core.sv
// AES-128 block encryption core, iterative, one round per cycle.
// The key is added at accept, then one round per cycle; the result is held
// valid in the done state until it is taken. A new item is taken only after
// the result has left, as the round unit is shared by all rounds. Synchronous
// active-low reset clears control and the key registers. Depends on aes_pkg,
// aes_ctrl, aes_dpath.
module aes128_block_encrypt_core import aes_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [63:0] i_plain_low,
    input  logic [63:0] i_plain_high,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [63:0] o_cipher_low,
    output logic [63:0] o_cipher_high
);
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    logic [63:0]  r_key_low, r_key_high;
    t_dp_cmd      cmd;
    logic [127:0] blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    aes_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (cmd)
    );

    aes_dpath u_dpath (
        .i_clk   (i_clk),
        .i_cmd   (cmd),
        .i_key   ({r_key_high, r_key_low}),
        .i_plain ({i_plain_high, i_plain_low}),
        .o_block (blk)
    );

    assign o_cipher_low  = blk[63:0];
    assign o_cipher_high = blk[127:64];
endmodule

FILE: sim/tb_aes128_block_encrypt_core.sv
// Self-checking testbench for the AES-128 block encryption core.
// Predicts ciphertext with its own FIPS-197 cipher; depends on the core RTL (and, through it, aes_pkg).
module tb_aes128_block_encrypt_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_block;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = 1'b0;
    logic [63:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [63:0] i_plain_low = '0;
    logic [63:0] i_plain_high = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_cipher_low;
    logic [63:0] o_cipher_high;

    aes128_block_encrypt_core DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_block      plain_q[$];
    t_block      cipher_q[$];
    logic [63:0] key_lo_m = '0, key_hi_m = '0;
    bit          failed = 0;
    bit          calm = 0;      // no idling in the closing stretch
    int          hold_off = 0;  // long receiver stall request

    logic [7:0] sbox_tbl[256];
    initial begin
        logic [7:0] p, q, x;
        // build the S-box from inverse and affine map
        p = 8'h01; q = 8'h01;
        sbox_tbl[0] = 8'h63;
        do begin
            p = p ^ {p[6:0], 1'b0} ^ (p[7] ? 8'h1b : 8'h00);
            q = q ^ {q[6:0], 1'b0};
            q = q ^ {q[5:0], 2'b0};
            q = q ^ {q[3:0], 4'b0};
            if (q[7]) q = q ^ 8'h09;
            x = q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
                ^ {q[3:0], q[7:4]};
            sbox_tbl[p] = x ^ 8'h63;
        end while (p != 8'h01);
    end

    function automatic logic [7:0] dbl(logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_block encrypt_block(t_block pt, logic [63:0] klo, logic [63:0] khi);
        logic [7:0] s[16], k[16], t[16];
        logic [7:0] rc, a0, a1, a2, a3;
        t_block r;
        rc = 8'h01;
        for (int j = 0; j < 8; j++) begin
            s[j] = pt.lo[8*j +: 8]; s[j+8] = pt.hi[8*j +: 8];
            k[j] = klo[8*j +: 8];   k[j+8] = khi[8*j +: 8];
        end
        for (int j = 0; j < 16; j++) s[j] ^= k[j];
        for (int rnd = 1; rnd <= 10; rnd++) begin
            k[0] ^= sbox_tbl[k[13]] ^ rc;
            k[1] ^= sbox_tbl[k[14]];
            k[2] ^= sbox_tbl[k[15]];
            k[3] ^= sbox_tbl[k[12]];
            for (int j = 4; j < 16; j++) k[j] ^= k[j-4];
            rc = dbl(rc);
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    t[w + 4*c] = sbox_tbl[s[w + 4*((c + w) % 4)]];
            s = t;
            if (rnd < 10)
                for (int c = 0; c < 4; c++) begin
                    a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
                    s[4*c]   = dbl(a0) ^ a1 ^ dbl(a1) ^ a2 ^ a3;
                    s[4*c+1] = a0 ^ dbl(a1) ^ a2 ^ dbl(a2) ^ a3;
                    s[4*c+2] = a0 ^ a1 ^ dbl(a2) ^ a3 ^ dbl(a3);
                    s[4*c+3] = a0 ^ dbl(a0) ^ a1 ^ a2 ^ dbl(a3);
                end
            for (int j = 0; j < 16; j++) s[j] ^= k[j];
        end
        for (int j = 0; j < 8; j++) begin
            r.lo[8*j +: 8] = s[j]; r.hi[8*j +: 8] = s[j+8];
        end
        return r;
    endfunction

    // handshake flag o_ready sampled at the rising edge
    logic o_ready_s = 1'b0;
    always @(posedge i_clk) o_ready_s <= o_ready;

    // Driver: offers queued items, random gaps
    int gap = 0;
    always @(negedge i_clk) begin
        if (i_valid && o_ready_s) begin
            plain_q.pop_front();
        end
        if (!i_valid || o_ready_s) begin
            if (gap > 0) begin
                gap--;
                i_valid <= 1'b0;
            end else if (i_rst_n && plain_q.size() > 0) begin
                i_valid      <= 1'b1;
                i_plain_low  <= plain_q[0].lo;
                i_plain_high <= plain_q[0].hi;
                cipher_q.push_back(encrypt_block(plain_q[0], key_lo_m, key_hi_m));
                if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 6);
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: checks each accepted result, random stalls
    int stall = 0;
    always @(posedge i_clk) begin
        t_block want;
        if (o_valid && i_ready) begin
            if (cipher_q.size() == 0) begin
                $display("%0t: unexpected result %h %h", $time, o_cipher_high, o_cipher_low);
                failed = 1;
            end else begin
                want = cipher_q.pop_front();
                if (o_cipher_low !== want.lo) begin
                    $display("%0t: cipher_low expected %h actual %h",
                             $time, want.lo, o_cipher_low);
                    failed = 1;
                end
                if (o_cipher_high !== want.hi) begin
                    $display("%0t: cipher_high expected %h actual %h",
                             $time, want.hi, o_cipher_high);
                    failed = 1;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off--;
            i_ready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= i_rst_n;
            if (!calm && $urandom_range(0, 5) == 0) stall = $urandom_range(1, 6);
        end
    end

    function automatic t_block rand_block();
        t_block b;
        b.lo = {$urandom, $urandom};
        b.hi = {$urandom, $urandom};
        return b;
    endfunction

    task automatic write_reg(logic idx, logic [63:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == REG_KEY_LOW) key_lo_m = val;
        else                    key_hi_m = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (plain_q.size() > 0 || cipher_q.size() > 0 || i_valid) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic run_phase(int n);
        for (int i = 0; i < n; i++) plain_q.push_back(rand_block());
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        // reset key of zero
        plain_q.push_back('{64'h0, 64'h0});
        plain_q.push_back('{'1, '1});
        drain();
        // FIPS-197 appendix vector
        write_reg(REG_KEY_LOW,  64'h0706050403020100);
        write_reg(REG_KEY_HIGH, 64'h0f0e0d0c0b0a0908);
        plain_q.push_back('{64'h7766554433221100, 64'hffeeddccbbaa9988});
        plain_q.push_back('{64'h0, 64'h0});
        plain_q.push_back('{'1, '1});
        plain_q.push_back('{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555});
        for (int i = 0; i < 64; i++) plain_q.push_back('{64'h1 << i, 64'h1 << i});
        drain();
        write_reg(REG_KEY_LOW, '1);
        write_reg(REG_KEY_HIGH, '1);
        plain_q.push_back('{64'h0, 64'h0});
        plain_q.push_back('{'1, '1});
        drain();
        // long receiver stall while the sender keeps offering
        hold_off = 200;
        run_phase(30);
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(REG_KEY_LOW, {$urandom, $urandom});
            write_reg(REG_KEY_HIGH, {$urandom, $urandom});
            run_phase(80);
        end
        calm = 1;
        run_phase(40);
        if (failed)
            $display("FAILURE");
        else
            $display("SUCCESS");
        $finish;
    end

    initial begin
        #2ms;
        $display("FAILURE");
        $finish;
    end
endmodule
